FILE: rtl/hpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpl_pkg;

	localparam int MAX_BINS    = 1024;
	localparam int COUNT_WIDTH = 32;
	localparam int IDX_W       = $clog2(MAX_BINS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int PCT_W       = 7;
	localparam int TOTAL_W     = COUNT_WIDTH + IDX_W;
	localparam int PROD_W      = COUNT_WIDTH + PCT_W;
	localparam int CUM_W       = TOTAL_W + PCT_W;
	localparam int BIN_CNT_W   = 32;
	localparam int BIN_IDX_W   = 10;

	localparam logic [PCT_W-1:0] HUNDRED = PCT_W'(100);

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [BIN_CNT_W-1:0] bin_count;
		logic                 first;
		logic [PCT_W-1:0]     percent;
	} request_t;

	typedef struct packed {
		logic [BIN_IDX_W-1:0] bin_index;
		logic                 status;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic append;
		logic query_start;
		logic walk;
		logic flush;
		logic post_ok;
		logic post_empty;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic walk_done;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/hpl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hpl_ctrl import hpl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic req_type,
	input  wire sts_t sts,
	output logic      busy,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_APPEND) begin
						cmd.append = 1'b1;
					end else if (sts.empty) begin
						cmd.post_empty = 1'b1;
					end else begin
						cmd.query_start = 1'b1;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				busy     = 1'b1;
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					// drop whatever is still in flight behind the answering bin
					cmd.flush   = 1'b1;
					cmd.post_ok = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/hpl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module hpl_datapath import hpl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire request_t request,
	input  wire cmd_t     cmd,
	output sts_t          sts,
	output logic          done,
	output result_t       result
);

	logic [COUNT_WIDTH-1:0] mem [MAX_BINS];

	logic [CNT_W-1:0]   loaded_q;
	logic [TOTAL_W-1:0] total_q;
	logic [CUM_W-1:0]   thr_q;
	logic [CUM_W-1:0]   cum_q;
	logic [CNT_W-1:0]   rd_cnt_q;

	logic [COUNT_WIDTH-1:0] rdata_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   vld_s1;
	logic                   last_s1;

	logic [PROD_W-1:0] prod_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic              vld_s2;
	logic              last_s2;

	logic              done_q;
	result_t           result_q;

	logic [CNT_W-1:0]       base;
	logic [COUNT_WIDTH-1:0] cnt;
	logic                   wr_en;
	logic                   issue;
	logic                   issue_last;
	logic [PCT_W-1:0]       psat;
	logic [CUM_W-1:0]       cum_next;
	logic                   hit;

	assign base  = request.first ? '0 : loaded_q;
	assign cnt   = COUNT_WIDTH'(request.bin_count);
	assign wr_en = cmd.append && (base < CNT_W'(MAX_BINS));

	assign issue      = cmd.walk && (rd_cnt_q < loaded_q);
	assign issue_last = (rd_cnt_q == loaded_q - CNT_W'(1));

	assign psat = (request.percent > HUNDRED) ? HUNDRED : request.percent;

	assign cum_next = cum_q + CUM_W'(prod_s2);
	assign hit      = cum_next >= thr_q;

	assign sts.empty     = (loaded_q == '0);
	assign sts.walk_done = vld_s2 && (hit || last_s2);

	// bin memory: one write port for appends, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[base[IDX_W-1:0]] <= cnt;
		end
		rdata_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_cnt_q[IDX_W-1:0];
		last_s1 <= issue_last;
		prod_s2 <= PROD_W'(rdata_s1) * PROD_W'(HUNDRED);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		if (cmd.query_start) begin
			thr_q <= CUM_W'(total_q) * CUM_W'(psat);
		end
		if (cmd.query_start) begin
			cum_q <= '0;
		end else if (vld_s2) begin
			cum_q <= cum_next;
		end
		if (cmd.post_ok) begin
			result_q.bin_index <= BIN_IDX_W'(idx_s2);
			result_q.status    <= STATUS_OK;
		end else if (cmd.post_empty) begin
			result_q.bin_index <= '0;
			result_q.status    <= STATUS_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			total_q  <= '0;
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				loaded_q <= base + CNT_W'(1);
				total_q  <= (request.first ? '0 : total_q) + TOTAL_W'(cnt);
			end
			if (cmd.query_start) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			vld_s1 <= issue && !cmd.flush;
			vld_s2 <= vld_s1 && !cmd.flush;
			done_q <= cmd.post_ok || cmd.post_empty;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: rtl/histogram_percentile_locator_top.sv
// Append beat: taken while idle, busy stays low, no result strobe.
// Query beat: busy while the walk reads one bin per cycle from bin 0 up to the answering
// bin; the result strobe follows through the read and scale registers.
// Empty query: result strobe on the cycle after the accepting edge.
// Results are shown for one cycle under done; the receiver cannot stall.
// Reset clears bin count, total and control state; the bin memory keeps no reset.
`timescale 1ns / 1ps
`default_nettype none

module histogram_percentile_locator_top import hpl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire request_t request,
	output logic          done,
	output result_t       result
);

	cmd_t cmd;
	sts_t sts;

	// Controller: accept beats while idle, route appends straight to the store,
	// and hold busy for the length of a percentile walk.
	hpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (request.req_type),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	// Datapath: bin memory, running total, and the walk pipeline
	// (read, scale by one hundred, accumulate and compare against total*percent).
	hpl_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire
